@@ design/vnorm_pkg.sv @@
// vnorm_pkg: shared constants for the vector normalize pipeline
// no dependencies; imported by every module of the block
package vnorm_pkg;

  // fixed width of each input component on the stream
  localparam int VEC_W = 32;

  // parameter defaults
  localparam int DEF_IN_WIDTH  = 32;
  localparam int DEF_FRAC_BITS = 16;

endpackage

@@ design/vector3_normalize_unit.sv @@
// vector3_normalize_unit: pipelined normalize of a three-component vector
// throughput one vector per cycle while the output is not stalled; the square root and the three dividers retire
// one bit per stage, so their stage counts set the latency
// a stall at the output holds every stage in place
// reset (rst_n, synchronous) clears the stage valid bits only; no clearing pass
module vector3_normalize_unit
  import vnorm_pkg::*;
#(
  parameter int IN_WIDTH  = DEF_IN_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  localparam int OUT_W    = FRAC_BITS + 2,
  localparam int OUT_DW   = ((3 * OUT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [3*VEC_W-1:0]  in_tdata,   // vec_x, vec_y, vec_z
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_DW-1:0]   out_tdata,  // unit_x, unit_y, unit_z, zero pad
  output logic                out_tuser   // nonzero
);

  localparam int MW  = IN_WIDTH;
  localparam int SQ  = MW + 1;
  localparam int DV  = FRAC_BITS + 1;
  localparam int MLN = 4 + SQ;          // mag line: stage 1 up to divider entry
  localparam int NLN = MLN + DV;        // sign line: stage 1 up to output
  localparam int NST = NLN + 1;
  localparam int QW  = FRAC_BITS + 1;

  logic en;
  logic [NST-1:0] vld_r;

  assign en        = ~vld_r[NST-1] | out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // stage 1: split into magnitude and sign
  logic [MW-1:0] mag_nxt [3];
  logic [2:0]    neg_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [MW-1:0] v;
      v          = in_tdata[i*VEC_W +: MW];
      neg_nxt[i] = v[MW-1];
      mag_nxt[i] = v[MW-1] ? (~v + 1'b1) : v;
    end
  end

  logic [MW-1:0] mag_r [MLN][3];
  logic [2:0]    neg_r [NLN];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= mag_nxt;
      neg_r[0] <= neg_nxt;
      for (int k = 1; k < MLN; k++) mag_r[k] <= mag_r[k-1];
      for (int k = 1; k < NLN; k++) neg_r[k] <= neg_r[k-1];
    end
  end

  // stages 2 to 4: squares, then two adds
  logic [2*MW-1:0] sq_r [3];
  logic [2*MW:0]   sxy_r;
  logic [2*MW-1:0] sz_r;
  logic [2*MW+1:0] sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= mag_r[0][i] * mag_r[0][i];
      sxy_r <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
      sz_r  <= sq_r[2];
      sum_r <= {1'b0, sxy_r} + {2'b00, sz_r};
    end
  end

  logic [MW-1:0] root;

  vnorm_sqrt #(.MW(MW)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad_in   (sum_r),
    .root_out (root)
  );

  // zero-length flag travels beside the dividers
  logic nz_r [DV];

  always_ff @(posedge clk) begin
    if (en) begin
      nz_r[0] <= (root != '0);
      for (int k = 1; k < DV; k++) nz_r[k] <= nz_r[k-1];
    end
  end

  logic [QW-1:0] quot [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vnorm_div #(.MW(MW), .FRAC(FRAC_BITS)) u_div (
      .clk  (clk),
      .en   (en),
      .mag  (mag_r[MLN-1][i]),
      .len  (root),
      .quot (quot[i])
    );
  end

  // output stage: apply sign, force zero on a zero vector
  logic [OUT_W-1:0] unit_r [3];
  logic             nz_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nz_out_r <= nz_r[DV-1];
      for (int i = 0; i < 3; i++) begin
        if (!nz_r[DV-1]) begin
          unit_r[i] <= '0;
        end else if (neg_r[NLN-1][i]) begin
          unit_r[i] <= ~{1'b0, quot[i]} + 1'b1;
        end else begin
          unit_r[i] <= {1'b0, quot[i]};
        end
      end
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tuser  = nz_out_r;
  assign out_tdata  = {{(OUT_DW - 3*OUT_W){1'b0}}, unit_r[2], unit_r[1], unit_r[0]};

`ifndef SYNTHESIS
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("zero-length result carries nonzero components");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow pipeline advance");
`endif

endmodule

@@ design/vnorm_sqrt.sv @@
// vnorm_sqrt: pipelined floor square root, one root bit per register stage
// depends on vnorm_pkg
module vnorm_sqrt
  import vnorm_pkg::*;
#(
  parameter int MW = DEF_IN_WIDTH
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*MW+1:0]     rad_in,
  output logic [MW-1:0]       root_out
);

  localparam int SW = 2 * MW + 2;
  localparam int NS = MW + 1;
  localparam int RW = MW + 2;
  localparam int QW = MW + 1;

  logic [SW-1:0] rad_r  [NS];
  logic [RW-1:0] rem_r  [NS];
  logic [QW-1:0] root_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [SW-1:0] rad_p;
    logic [RW-1:0] rem_p;
    logic [QW-1:0] root_p;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;
    logic [SW-1:0] rad_nxt;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign rad_p  = rad_in;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end

    always_comb begin
      // bring down the next two radicand bits and try root*4+1
      cur      = {rem_p, rad_p[SW-1 -: 2]};
      trial    = {1'b0, root_p, 2'b01};
      diff     = cur - trial;
      ge       = (cur >= trial);
      rad_nxt  = {rad_p[SW-3:0], 2'b00};
      rem_nxt  = ge ? diff[RW-1:0] : cur[RW-1:0];
      root_nxt = {root_p[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_nxt;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign root_out = root_r[NS-1][MW-1:0];

endmodule

@@ design/vnorm_div.sv @@
// vnorm_div: pipelined restoring divider, mag * 2^FRAC / len, one quotient bit a stage
// depends on vnorm_pkg; expects mag <= len
module vnorm_div
  import vnorm_pkg::*;
#(
  parameter int MW   = DEF_IN_WIDTH,
  parameter int FRAC = DEF_FRAC_BITS
) (
  input  logic            clk,
  input  logic            en,
  input  logic [MW-1:0]   mag,
  input  logic [MW-1:0]   len,
  output logic [FRAC:0]   quot
);

  localparam int NS = FRAC + 1;
  localparam int QW = FRAC + 1;

  logic [MW-1:0] rem_r [NS];
  logic [MW-1:0] len_r [NS];
  logic [QW-1:0] q_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [MW:0]   cur;
    logic [MW-1:0] len_p;
    logic [QW-1:0] q_p;
    logic [MW:0]   diff;
    logic          ge;
    logic [MW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign cur   = {1'b0, mag};
      assign len_p = len;
      assign q_p   = '0;
    end else begin : g_next
      assign cur   = {rem_r[k-1], 1'b0};
      assign len_p = len_r[k-1];
      assign q_p   = q_r[k-1];
    end

    always_comb begin
      diff    = cur - {1'b0, len_p};
      ge      = (cur >= {1'b0, len_p});
      rem_nxt = ge ? diff[MW-1:0] : cur[MW-1:0];
      q_nxt   = {q_p[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        len_r[k] <= len_p;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign quot = q_r[NS-1];

endmodule

@@ test/testbench.sv @@
// testbench: checks vector3_normalize_unit against a predictor of the
// integer normalize (exact sum of squares, floor square root, truncating divide)
// depends on vnorm_pkg and vector3_normalize_unit
module testbench;
  import vnorm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_W  = DEF_FRAC_BITS + 2;
  localparam int OUT_DW = ((3 * OUT_W + 7) / 8) * 8;
  localparam int LATENCY = 4 + (DEF_IN_WIDTH + 1) + OUT_W;

  typedef struct packed {
    logic             nonzero;
    logic [OUT_W-1:0] uz;
    logic [OUT_W-1:0] uy;
    logic [OUT_W-1:0] ux;
  } unit_vec_t;

  class norm_scoreboard;
    unit_vec_t pending[$];
    int mismatches;

    function logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function void note_vector(logic [3*VEC_W-1:0] data);
      logic [63:0] mag[3];
      logic        neg[3];
      logic [63:0] sumsq;
      logic [63:0] len;
      logic [63:0] q;
      logic [OUT_W-1:0] comp[3];
      unit_vec_t u;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        logic [31:0] raw;
        raw = data[i*VEC_W +: VEC_W];
        neg[i] = raw[31];
        mag[i] = neg[i] ? {32'd0, -raw} : {32'd0, raw};
        sumsq = sumsq + mag[i] * mag[i];
      end
      len = floor_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
        if (len == 0) begin
          comp[i] = 0;
        end else begin
          q = (mag[i] << DEF_FRAC_BITS) / len;
          if (neg[i]) q = -q;
          comp[i] = q[OUT_W-1:0];
        end
      end
      u.ux = comp[0];
      u.uy = comp[1];
      u.uz = comp[2];
      u.nonzero = (len != 0);
      pending.push_back(u);
    endfunction

    function void check_result(logic [OUT_DW-1:0] data, logic flag);
      unit_vec_t want;
      unit_vec_t got;
      got = {flag, data[3*OUT_W-1:0]};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want || data[OUT_DW-1:3*OUT_W] !== '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want x=%h y=%h z=%h nz=%b got x=%h y=%h z=%h nz=%b",
                   want.ux, want.uy, want.uz, want.nonzero,
                   got.ux, got.uy, got.uz, got.nonzero);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [3*VEC_W-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tuser;

  norm_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  vector3_normalize_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 15) - 8;
      4: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // one request, with a random gap before it
  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_vector({z, y, x});
  endtask

  // receiver; a long hold-off while hold_cycles counts down
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [31:0] edge_vals[6];
    int waited;
    board = new();
    edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd1, 32'hffff_ffff, 32'd3};
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    send_idle_pct = 35;
    recv_idle_pct = 57;
    hold_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, zero vector, axis vectors, mixed signs
    for (int i = 0; i < 6; i++)
      send_vector(edge_vals[i], edge_vals[(i + 1) % 6], edge_vals[(i + 3) % 6]);
    send_vector(0, 0, 0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(0, 32'hffff_ffff, 0);
    send_vector(0, 0, 32'h8000_0000);
    send_vector(3, 4, 0);
    send_vector(-3, 4, -12);
    send_vector(1, 1, 1);
    send_vector(32'h8000_0000, 32'h7fff_ffff, 1);

    for (int n = 0; n < 1650; n++) begin
      if (n == 550) begin
        send_idle_pct = 57;
        recv_idle_pct = 35;
      end
      if (n == 1100) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
      end
      send_vector(pick_component(), pick_component(), pick_component());
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
